// ===== rtl/sid_pkg.sv =====
`default_nettype none

package sid_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned DIGIT_W = 4;
    // five decimal digits cover 65535 and therefore any 16-bit magnitude
    localparam int unsigned NUM_DIGITS = 5;
    localparam int unsigned BIT_CNT_W  = 4;
    localparam int unsigned LEFT_W     = 3;

    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [DIGIT_W-1:0] t_digit;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_CLEAR  = 2'd1,
        CELL_DABBLE = 2'd2,
        CELL_SHIFT  = 2'd3
    } t_cell_op;

endpackage

`default_nettype wire

// ===== rtl/sid_ifs.sv =====
`default_nettype none

interface sid_in_if;
    import sid_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface sid_out_if;
    import sid_pkg::*;

    logic  valid;
    logic  ready;
    t_char ascii_char;
    logic  last_char;

    modport source (output valid, output ascii_char, output last_char, input ready);
    modport sink (input valid, input ascii_char, input last_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// Signed 16-bit word to decimal ASCII text.
// i_in carries one 16-bit word per beat; words above 32767 are two's
// complement negatives. o_out returns the signed decimal text one character
// per beat, most significant digit first, no leading zeros, with last_char
// set on the final character. A negative word starts with '-'.
// Conversion runs through a row of five bcd digit cells, one shift-and-add-3
// step per cycle over the 16 bits of the magnitude. Characters then leave
// from the top cell as the row shifts up one digit per cycle while o_out
// is not stalled, leading zeros being dropped in passing. i_in.ready is
// high only between words. A stalled receiver holds the output register
// until the character is taken; the row of cells holds as well, though
// leading zeros may still be dropped meanwhile. The last character may still
// wait while the next word is accepted.
// Reset clears the control state and the output valid; no item is pending.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sid_in_if.sink    i_in,
    sid_out_if.source o_out
);
    import sid_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                r_state, n_state;
    t_value                r_mag, n_mag;
    logic                  r_sign, n_sign;
    logic                  r_digit_seen, n_digit_seen;
    logic [BIT_CNT_W-1:0]  r_bits, n_bits;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_out_valid, n_out_valid;
    t_char                 r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;
    t_cell_op              w_op;
    logic                  w_in_fire;
    logic                  w_out_free;
    logic                  w_bit [NUM_DIGITS];
    t_digit                w_digit [NUM_DIGITS];
    t_digit                w_top;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_top      = w_digit[NUM_DIGITS-1];

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.ascii_char = r_out_char;
    assign o_out.last_char  = r_out_last;

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++) begin : g_cells
            if (g == 0) begin : g_low
                sid_cell u_cell (
                    .i_clk   (i_clk),
                    .i_op    (w_op),
                    .i_bit   (r_mag[VALUE_W-1]),
                    .i_digit ('0),
                    .o_bit   (w_bit[g]),
                    .o_digit (w_digit[g])
                );
            end else begin : g_up
                sid_cell u_cell (
                    .i_clk   (i_clk),
                    .i_op    (w_op),
                    .i_bit   (w_bit[g-1]),
                    .i_digit (w_digit[g-1]),
                    .o_bit   (w_bit[g]),
                    .o_digit (w_digit[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_mag        = r_mag;
        n_sign       = r_sign;
        n_digit_seen = r_digit_seen;
        n_bits       = r_bits;
        n_left       = r_left;
        n_out_valid  = r_out_valid;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        w_op         = CELL_HOLD;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_sign       = i_in.value[VALUE_W-1];
                    n_mag        = i_in.value[VALUE_W-1] ? VALUE_W'(~i_in.value + 1'b1)
                                                         : i_in.value;
                    n_digit_seen = 1'b0;
                    n_bits       = '1;
                    w_op         = CELL_CLEAR;
                    n_state      = ST_CONV;
                end
            end
            ST_CONV: begin
                w_op  = CELL_DABBLE;
                n_mag = {r_mag[VALUE_W-2:0], 1'b0};
                n_bits = r_bits - 1'b1;
                if (r_bits == '0) begin
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_sign) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_char  = CHAR_MINUS;
                        n_out_last  = 1'b0;
                        n_sign      = 1'b0;
                    end
                end else if (!r_digit_seen && w_top == '0 && r_left != LEFT_W'(1)) begin
                    // leading zero: drop it without a beat
                    w_op   = CELL_SHIFT;
                    n_left = r_left - 1'b1;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = CHAR_ZERO + CHAR_W'(w_top);
                    n_out_last   = (r_left == LEFT_W'(1));
                    n_digit_seen = 1'b1;
                    w_op         = CELL_SHIFT;
                    n_left       = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_sign       <= 1'b0;
            r_digit_seen <= 1'b0;
            r_bits       <= '0;
            r_left       <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_sign       <= n_sign;
            r_digit_seen <= n_digit_seen;
            r_bits       <= n_bits;
            r_left       <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule

`default_nettype wire

// ===== rtl/sid_cell.sv =====
`default_nettype none

module sid_cell (
    input  wire logic              i_clk,
    input  wire sid_pkg::t_cell_op i_op,
    input  wire logic              i_bit,
    input  wire sid_pkg::t_digit   i_digit,
    output logic                   o_bit,
    output sid_pkg::t_digit        o_digit
);
    import sid_pkg::*;

    t_digit r_digit;
    t_digit n_digit;
    t_digit w_adj;

    // add-3 correction before the shift keeps the digit in bcd range
    assign w_adj   = (r_digit >= DABBLE_MIN) ? (r_digit + DABBLE_ADD) : r_digit;
    assign o_bit   = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        case (i_op)
            CELL_HOLD:   n_digit = r_digit;
            CELL_CLEAR:  n_digit = '0;
            CELL_DABBLE: n_digit = {w_adj[DIGIT_W-2:0], i_bit};
            CELL_SHIFT:  n_digit = i_digit;
            default:     n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

`default_nettype wire
